[src/bcr_pkg.sv]
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants of the branch, call and return unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int ADDR_W          = 16;
    localparam int CYC_W           = 5;

    localparam logic [1:0] KIND_JUMP    = 2'd0;
    localparam logic [1:0] KIND_CALL    = 2'd1;
    localparam logic [1:0] KIND_RETURN  = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    localparam logic [CYC_W-1:0] CYC_TAKEN     = 5'd22;
    localparam logic [CYC_W-1:0] CYC_NOT_TAKEN = 5'd18;
    localparam logic [CYC_W-1:0] CYC_RESTART   = 5'd10;

    typedef enum logic [2:0] {
        OP_JUMP    = 3'd0,
        OP_CALL    = 3'd1,
        OP_RETURN  = 3'd2,
        OP_RESTART = 3'd3,
        OP_SKIP1   = 3'd4,
        OP_SKIP3   = 3'd5
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [ADDR_W-1:0] target;
        logic [2:0]        vector;
    } cmd_t;

endpackage

`default_nettype wire

[src/bcr_front.sv]
// ----------------------------------------------------------------------------
// bcr_front
// Decodes an incoming word into an operation for the execution side.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_front (
    input  wire logic [1:0]              s_kind,
    input  wire logic                    s_conditional,
    input  wire logic [1:0]              s_cond_select,
    input  wire logic                    s_cond_sense,
    input  wire logic [3:0]              s_flags,
    input  wire logic [bcr_pkg::ADDR_W-1:0] s_target_address,
    input  wire logic [2:0]              s_rst_vector,
    output bcr_pkg::cmd_t                cmd
);
    import bcr_pkg::*;

    logic go;

    assign go = !s_conditional || (s_flags[s_cond_select] == s_cond_sense);

    always_comb begin
        cmd.target = s_target_address;
        cmd.vector = s_rst_vector;
        unique case (s_kind)
            KIND_JUMP:    cmd.op = go ? OP_JUMP : OP_SKIP3;
            KIND_CALL:    cmd.op = go ? OP_CALL : OP_SKIP3;
            KIND_RETURN:  cmd.op = go ? OP_RETURN : OP_SKIP1;
            default:      cmd.op = OP_RESTART;
        endcase
    end

endmodule

`default_nettype wire

[src/bcr_queue.sv]
// ----------------------------------------------------------------------------
// bcr_queue
// Two-entry queue of decoded operations between decode and execution.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire bcr_pkg::cmd_t  push_cmd,
    output logic                not_full,
    input  wire logic           pop,
    output bcr_pkg::cmd_t       pop_cmd,
    output logic                not_empty
);
    import bcr_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[src/bcr_exec.sv]
// ----------------------------------------------------------------------------
// bcr_exec
// Holds the program counter and return stack and executes one operation a
// cycle into the output register while that register is empty or being taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_exec #(
    parameter int STACK_DEPTH = bcr_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cmd_valid,
    input  wire bcr_pkg::cmd_t              cmd,
    output logic                            cmd_pop,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [bcr_pkg::ADDR_W-1:0]      m_next_pc,
    output logic                            m_taken,
    output logic [bcr_pkg::CYC_W-1:0]       m_cycle_count
);
    import bcr_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_LAST = SP_W'(STACK_DEPTH - 1);

    logic [ADDR_W-1:0] mem [STACK_DEPTH];
    logic              vld_reg [STACK_DEPTH];

    logic [ADDR_W-1:0] pc_reg, pc_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [ADDR_W-1:0] tos_reg, tos_next;
    logic [ADDR_W-1:0] rd_data_reg;
    logic              rd_vld_reg;
    logic [SP_W-1:0]   rd_addr;
    logic [SP_W-1:0]   sp_dec;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_data;

    logic              m_valid_reg;
    logic [ADDR_W-1:0] out_pc_reg;
    logic              out_taken_reg, out_taken_next;
    logic [CYC_W-1:0]  out_cyc_reg, out_cyc_next;

    assign cmd_pop = cmd_valid && (!m_valid_reg || m_ready);
    assign sp_dec  = (sp_reg == '0) ? SP_LAST : sp_reg - 1'b1;
    assign rd_addr = (sp_next == SP_LAST) ? '0 : sp_next + 1'b1;

    always_comb begin
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        tos_next       = tos_reg;
        wr_en          = 1'b0;
        wr_data        = pc_reg + ADDR_W'(3);
        out_taken_next = 1'b1;
        out_cyc_next   = CYC_TAKEN;
        if (cmd_pop) begin
            unique case (cmd.op)
                OP_JUMP: begin
                    pc_next = cmd.target;
                end
                OP_CALL: begin
                    pc_next  = cmd.target;
                    sp_next  = sp_dec;
                    wr_en    = 1'b1;
                    tos_next = wr_data;
                end
                OP_RETURN: begin
                    pc_next  = tos_reg;
                    sp_next  = (sp_reg == SP_LAST) ? '0 : sp_reg + 1'b1;
                    tos_next = rd_vld_reg ? rd_data_reg : '0;
                end
                OP_RESTART: begin
                    pc_next      = {10'd0, cmd.vector, 3'd0};
                    sp_next      = sp_dec;
                    wr_en        = 1'b1;
                    wr_data      = pc_reg + ADDR_W'(1);
                    tos_next     = wr_data;
                    out_cyc_next = CYC_RESTART;
                end
                OP_SKIP1: begin
                    pc_next        = pc_reg + ADDR_W'(1);
                    out_taken_next = 1'b0;
                    out_cyc_next   = CYC_NOT_TAKEN;
                end
                default: begin
                    pc_next        = pc_reg + ADDR_W'(3);
                    out_taken_next = 1'b0;
                    out_cyc_next   = CYC_NOT_TAKEN;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            sp_reg      <= '0;
            tos_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < STACK_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else begin
            pc_reg     <= pc_next;
            sp_reg     <= sp_next;
            tos_reg    <= tos_next;
            rd_vld_reg <= vld_reg[rd_addr];
            if (wr_en) begin
                vld_reg[sp_next] <= 1'b1;
            end
            if (cmd_pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) begin
            mem[sp_next] <= wr_data;
        end
        if (cmd_pop) begin
            out_pc_reg    <= pc_next;
            out_taken_reg <= out_taken_next;
            out_cyc_reg   <= out_cyc_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_next_pc     = out_pc_reg;
    assign m_taken       = out_taken_reg;
    assign m_cycle_count = out_cyc_reg;

    a_sp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SP_LAST)
        else $error("stack pointer out of range");

    a_not_taken_cycles: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_taken_reg) |-> (out_cyc_reg == CYC_NOT_TAKEN))
        else $error("untaken result charged wrong cycle count");

    a_stall_holds_pc: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(pc_reg))
        else $error("program counter moved while result stalled");

    a_push_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> vld_reg[sp_reg])
        else $error("pushed stack entry not marked valid");

endmodule

`default_nettype wire

[src/branch_call_return_unit_core.sv]
// ----------------------------------------------------------------------------
// branch_call_return_unit_core
// Executes jump, call, return and restart words against an internal program
// counter and return stack.
//
//   Channel   Direction  Handshake           Contents
//   s_*       in         s_valid / s_ready   kind, condition, flags, target, vector
//   m_*       out        m_valid / m_ready   next pc, taken, cycle count
//
// One word is accepted per cycle while the queue has room. The accepting edge
// writes it into the queue; once the output register is free, the single
// execute stage that updates the pc and stack pointer registers its result there.
// The two-entry queue between decode and execute takes two more words while a
// result waits in the output register; after that s_ready drops.
// Reset is synchronous; the stack reads as zero until written, with no
// clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module branch_call_return_unit_core #(
    parameter int STACK_DEPTH = bcr_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [1:0]                 s_kind,
    input  wire logic                       s_conditional,
    input  wire logic [1:0]                 s_cond_select,
    input  wire logic                       s_cond_sense,
    input  wire logic [3:0]                 s_flags,
    input  wire logic [bcr_pkg::ADDR_W-1:0] s_target_address,
    input  wire logic [2:0]                 s_rst_vector,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [bcr_pkg::ADDR_W-1:0]      m_next_pc,
    output logic                            m_taken,
    output logic [bcr_pkg::CYC_W-1:0]       m_cycle_count
);
    import bcr_pkg::*;

    cmd_t dec_cmd;
    cmd_t q_cmd;
    logic q_not_full;
    logic q_not_empty;
    logic q_pop;

    assign s_ready = q_not_full;

    bcr_front u_front (
        .s_kind           (s_kind),
        .s_conditional    (s_conditional),
        .s_cond_select    (s_cond_select),
        .s_cond_sense     (s_cond_sense),
        .s_flags          (s_flags),
        .s_target_address (s_target_address),
        .s_rst_vector     (s_rst_vector),
        .cmd              (dec_cmd)
    );

    bcr_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid && q_not_full),
        .push_cmd  (dec_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_cmd   (q_cmd),
        .not_empty (q_not_empty)
    );

    bcr_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (q_not_empty),
        .cmd           (q_cmd),
        .cmd_pop       (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_next_pc     (m_next_pc),
        .m_taken       (m_taken),
        .m_cycle_count (m_cycle_count)
    );

endmodule

`default_nettype wire
